// ===== rtl/wsfp_pkg.sv =====
package wsfp_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] TEXT_LIMIT_RESET = 16'd1023;

    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_BINARY = 2'd1;
    localparam logic [1:0] KIND_PING   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] CLASS_TEXT  = 3'd0;
    localparam logic [2:0] CLASS_AUDIO = 3'd1;
    localparam logic [2:0] CLASS_EOS   = 3'd2;
    localparam logic [2:0] CLASS_PONG  = 3'd3;
    localparam logic [2:0] CLASS_CLOSE = 3'd4;
    localparam logic [2:0] CLASS_ERROR = 3'd5;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       msg_end;
        logic [2:0] msg_class;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    function automatic logic [7:0] sanitize(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == 8'h0A || c == 8'h0D || c == 8'h09) begin
            r = 8'h20;
        end else if (c < 8'h20 || c > 8'h7E) begin
            r = 8'h3F;
        end
        return r;
    endfunction

endpackage

// ===== rtl/websocket_frame_parser.sv =====
// Channel  Direction  Handshake               Payload
// s_       in         s_tvalid / s_tready     tdata: rx_byte; tuser: restart
// m_       out        m_tvalid / m_tready     tdata: data; tlast: message_end;
//                                             tuser: kind, message_class
// cfg_     in         cfg_valid / cfg_ready   cfg_data: text_limit
//
// One byte per cycle in while not full; results are queued, then registered.
// Byte parsing is combinational; a 4-entry queue feeds a registered output stage.
// Reset is synchronous on aresetn low; text_limit returns to 1023.
// s_tready drops only while the queue is full; cfg_ready is always high.
module websocket_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data
    output logic        m_tlast,
    output logic [4:0]  m_tuser,   // [1:0] kind, [4:2] message_class
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]        text_limit_reg, text_limit_next;
    logic               accept;
    logic               pop;
    wsfp_pkg::q_push_t  push;
    wsfp_pkg::q_stat_t  stat;
    wsfp_pkg::res_t     head;

    always_comb begin
        cfg_ready       = 1'b1;
        text_limit_next = (cfg_valid && cfg_ready) ? cfg_data : text_limit_reg;
        s_tready        = !stat.full;
        accept          = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_limit_reg <= wsfp_pkg::TEXT_LIMIT_RESET;
        end else begin
            text_limit_reg <= text_limit_next;
        end
    end

    wsfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .restart    (s_tuser),
        .text_limit (text_limit_reg),
        .push       (push)
    );

    wsfp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    wsfp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !stat.full)
        else $error("result pushed into a full queue");

    a_class_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[4:2] == wsfp_pkg::CLASS_TEXT))
        else $error("message class set on a beat that ends nothing");

    a_empty_beat_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == wsfp_pkg::KIND_NONE) |-> m_tlast)
        else $error("beat with no byte that ends nothing");

    a_restart_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser) |-> !push.valid)
        else $error("restart beat produced a result");

endmodule

// ===== rtl/wsfp_parser.sv =====
module wsfp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    input  logic                  restart,
    input  logic [15:0]           text_limit,
    output wsfp_pkg::q_push_t     push
);

    localparam logic [1:0] PH_HDR0 = 2'd0;
    localparam logic [1:0] PH_HDR1 = 2'd1;
    localparam logic [1:0] PH_EXT  = 2'd2;
    localparam logic [1:0] PH_PAY  = 2'd3;

    localparam logic [1:0] MK_NONE   = 2'd0;
    localparam logic [1:0] MK_TEXT   = 2'd1;
    localparam logic [1:0] MK_BINARY = 2'd2;

    localparam int L = wsfp_pkg::LENGTH_BITS;

    logic [1:0]   phase_reg, phase_next;
    logic         halted_reg, halted_next;
    logic [3:0]   ext_cnt_reg, ext_cnt_next;
    logic         fin_reg, fin_next;
    logic [3:0]   opcode_reg, opcode_next;
    logic [L-1:0] rem_reg, rem_next;
    logic [1:0]   mkind_reg, mkind_next;
    logic [15:0]  kept_reg, kept_next;
    logic         bin_seen_reg, bin_seen_next;

    logic         start;
    logic [L-1:0] len_val;
    logic [L-1:0] rem_dec;
    logic         last;
    logic         ends;
    logic [6:0]   len7;
    wsfp_pkg::res_t res;

    always_comb begin
        phase_next    = phase_reg;
        halted_next   = halted_reg;
        ext_cnt_next  = ext_cnt_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        rem_next      = rem_reg;
        mkind_next    = mkind_reg;
        kept_next     = kept_reg;
        bin_seen_next = bin_seen_reg;
        start         = 1'b0;
        len_val       = '0;
        len7          = rx_byte[6:0];
        rem_dec       = rem_reg - L'(rem_reg != '0);
        last          = (rem_dec == '0);
        ends          = 1'b0;
        push.valid    = 1'b0;
        res.kind      = wsfp_pkg::KIND_NONE;
        res.data      = 8'h00;
        res.msg_end   = 1'b0;
        res.msg_class = wsfp_pkg::CLASS_TEXT;

        if (accept) begin
            if (restart) begin
                phase_next    = PH_HDR0;
                halted_next   = 1'b0;
                ext_cnt_next  = '0;
                fin_next      = 1'b0;
                opcode_next   = '0;
                rem_next      = '0;
                mkind_next    = MK_NONE;
                kept_next     = '0;
                bin_seen_next = 1'b0;
            end else if (!halted_reg) begin
                case (phase_reg)
                    PH_HDR0: begin
                        fin_next    = rx_byte[7];
                        opcode_next = rx_byte[3:0];
                        phase_next  = PH_HDR1;
                    end
                    PH_HDR1: begin
                        if (rx_byte[7]) begin
                            halted_next   = 1'b1;
                            push.valid    = 1'b1;
                            res.msg_end   = 1'b1;
                            res.msg_class = wsfp_pkg::CLASS_ERROR;
                        end else if (len7 == 7'd126) begin
                            rem_next     = '0;
                            ext_cnt_next = 4'd2;
                            phase_next   = PH_EXT;
                        end else if (len7 == 7'd127) begin
                            rem_next     = '0;
                            ext_cnt_next = 4'd8;
                            phase_next   = PH_EXT;
                        end else begin
                            len_val = L'(len7);
                            start   = 1'b1;
                        end
                    end
                    PH_EXT: begin
                        len_val  = {rem_reg[L-9:0], rx_byte};
                        rem_next = len_val;
                        if (ext_cnt_reg != '0) begin
                            ext_cnt_next = ext_cnt_reg - 4'd1;
                        end
                        start = (ext_cnt_next == '0);
                    end
                    PH_PAY: begin
                        rem_next = rem_dec;
                        if (last) begin
                            phase_next = PH_HDR0;
                        end
                        if (opcode_reg == wsfp_pkg::OP_PING) begin
                            push.valid    = 1'b1;
                            res.kind      = wsfp_pkg::KIND_PING;
                            res.data      = rx_byte;
                            res.msg_end   = last;
                            res.msg_class = last ? wsfp_pkg::CLASS_PONG
                                                 : wsfp_pkg::CLASS_TEXT;
                        end else if (opcode_reg != wsfp_pkg::OP_PONG) begin
                            ends = last && fin_reg;
                            if (mkind_reg == MK_TEXT) begin
                                if (kept_reg < text_limit) begin
                                    kept_next = kept_reg + 16'd1;
                                    res.kind  = wsfp_pkg::KIND_TEXT;
                                    res.data  = wsfp_pkg::sanitize(rx_byte);
                                end
                            end else begin
                                bin_seen_next = 1'b1;
                                res.kind      = wsfp_pkg::KIND_BINARY;
                                res.data      = rx_byte;
                            end
                            push.valid = ends || (res.kind != wsfp_pkg::KIND_NONE);
                            if (ends) begin
                                res.msg_end   = 1'b1;
                                res.msg_class = (mkind_reg == MK_TEXT) ?
                                                wsfp_pkg::CLASS_TEXT :
                                                wsfp_pkg::CLASS_AUDIO;
                                mkind_next    = MK_NONE;
                                kept_next     = '0;
                                bin_seen_next = 1'b0;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HDR0;
                    end
                endcase

                if (start) begin
                    rem_next   = len_val;
                    phase_next = PH_PAY;
                    if (opcode_reg == wsfp_pkg::OP_PING) begin
                        if (len_val > L'(125)) begin
                            halted_next   = 1'b1;
                            push.valid    = 1'b1;
                            res.msg_end   = 1'b1;
                            res.msg_class = wsfp_pkg::CLASS_ERROR;
                        end else if (len_val == '0) begin
                            phase_next    = PH_HDR0;
                            push.valid    = 1'b1;
                            res.msg_end   = 1'b1;
                            res.msg_class = wsfp_pkg::CLASS_PONG;
                        end
                    end else if (opcode_reg == wsfp_pkg::OP_PONG) begin
                        if (len_val == '0) begin
                            phase_next = PH_HDR0;
                        end
                    end else if (opcode_reg == wsfp_pkg::OP_CLOSE) begin
                        halted_next   = 1'b1;
                        push.valid    = 1'b1;
                        res.msg_end   = 1'b1;
                        res.msg_class = wsfp_pkg::CLASS_CLOSE;
                    end else if ((opcode_reg == wsfp_pkg::OP_TEXT ||
                                  opcode_reg == wsfp_pkg::OP_BINARY) &&
                                 mkind_reg != MK_NONE) begin
                        halted_next   = 1'b1;
                        push.valid    = 1'b1;
                        res.msg_end   = 1'b1;
                        res.msg_class = wsfp_pkg::CLASS_ERROR;
                    end else if (opcode_reg != wsfp_pkg::OP_TEXT &&
                                 opcode_reg != wsfp_pkg::OP_BINARY &&
                                 (opcode_reg != wsfp_pkg::OP_CONT ||
                                  mkind_reg == MK_NONE)) begin
                        halted_next   = 1'b1;
                        push.valid    = 1'b1;
                        res.msg_end   = 1'b1;
                        res.msg_class = wsfp_pkg::CLASS_ERROR;
                    end else begin
                        if (opcode_reg == wsfp_pkg::OP_TEXT) begin
                            mkind_next = MK_TEXT;
                        end else if (opcode_reg == wsfp_pkg::OP_BINARY) begin
                            mkind_next = MK_BINARY;
                        end
                        if (len_val == '0) begin
                            phase_next = PH_HDR0;
                            if (fin_reg) begin
                                push.valid    = 1'b1;
                                res.msg_end   = 1'b1;
                                res.msg_class = (mkind_next == MK_TEXT) ?
                                                wsfp_pkg::CLASS_TEXT :
                                                (bin_seen_reg ? wsfp_pkg::CLASS_AUDIO
                                                              : wsfp_pkg::CLASS_EOS);
                                mkind_next    = MK_NONE;
                                kept_next     = '0;
                                bin_seen_next = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        push.res = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            halted_reg   <= 1'b0;
            ext_cnt_reg  <= '0;
            fin_reg      <= 1'b0;
            opcode_reg   <= '0;
            rem_reg      <= '0;
            mkind_reg    <= MK_NONE;
            kept_reg     <= '0;
            bin_seen_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            halted_reg   <= halted_next;
            ext_cnt_reg  <= ext_cnt_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            rem_reg      <= rem_next;
            mkind_reg    <= mkind_next;
            kept_reg     <= kept_next;
            bin_seen_reg <= bin_seen_next;
        end
    end

endmodule

// ===== rtl/wsfp_queue.sv =====
module wsfp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  wsfp_pkg::q_push_t  push,
    input  logic               pop,
    output wsfp_pkg::res_t     head,
    output wsfp_pkg::q_stat_t  stat
);

    localparam int AW = wsfp_pkg::QUEUE_AW;

    wsfp_pkg::res_t mem_reg [wsfp_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;
    logic           do_pop;

    always_comb begin
        stat.valid  = (count_reg != '0);
        stat.full   = (count_reg == (AW+1)'(wsfp_pkg::QUEUE_DEPTH));
        do_pop      = pop && stat.valid;
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push.valid ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push.valid) - (AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/wsfp_out.sv =====
module wsfp_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  wsfp_pkg::res_t     head,
    input  wsfp_pkg::q_stat_t  stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [4:0]         m_tuser
);

    logic           valid_reg, valid_next;
    wsfp_pkg::res_t res_reg;

    always_comb begin
        pop        = stat.valid && (!valid_reg || m_tready);
        valid_next = pop || (valid_reg && !m_tready);
        m_tvalid   = valid_reg;
        m_tdata    = res_reg.data;
        m_tlast    = res_reg.msg_end;
        m_tuser    = {res_reg.msg_class, res_reg.kind};
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule
